@@ hw/rtl/tbbf_pkg.sv @@
package tbbf_pkg;

   // Tile columns with their own entry
   localparam int TILE_SLOTS = 64;
   localparam int SLOT_W     = $clog2(TILE_SLOTS);
   localparam int TCOL_W     = SLOT_W + 1;

   // Widths of registers, counters and result fields
   localparam int DIM_W      = 13;
   localparam int POS_W      = 12;
   localparam int ACROSS_W   = 7;
   localparam int INDEX_W    = 18;
   localparam int ALPHA_W    = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // Register indexes of the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_TILE_WIDTH   = 3'd1,
      CSR_TILE_HEIGHT  = 3'd2,
      CSR_TILES_ACROSS = 3'd3,
      CSR_TILES_DOWN   = 3'd4
   } tbbf_csr_type;

   // Progress of one tile column within the current band
   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_WIDTH  = 2'd1,
      PH_HEIGHT = 2'd2,
      PH_DONE   = 2'd3
   } tbbf_phase_type;

   // Effective configuration (zero acts as one, tiles across clamped)
   typedef struct packed {
      logic [DIM_W-1:0]    iw;
      logic [DIM_W-1:0]    tw;
      logic [DIM_W-1:0]    th;
      logic [ACROSS_W-1:0] ta;
      logic [DIM_W-1:0]    td;
   } tbbf_cfg_type;

   // One word of the per tile column memory
   typedef struct packed {
      tbbf_phase_type   phase;
      logic [DIM_W-1:0] corner_col;
      logic [POS_W-1:0] corner_row;
      logic [DIM_W-1:0] corner_rit;   // row within the tile band
      logic [DIM_W-1:0] run_w;
      logic [DIM_W-1:0] run_h;
   } tbbf_entry_type;

   // Pixel beat handed from the scan stage to the update stage
   typedef struct packed {
      logic               active;       // pixel maps to a tile column entry
      logic               emit;         // tile's bottom-right pixel
      logic               painted;
      logic               tile_right;
      logic               clear_before; // frame start: band restarts first
      logic               clear_after;  // last row of the band ends here
      logic [SLOT_W-1:0]  addr;
      logic [DIM_W-1:0]   pixel_col;
      logic [POS_W-1:0]   pixel_row;
      logic [DIM_W-1:0]   row_in_tile;
      logic [INDEX_W-1:0] tile_index;
      logic               last_tile;
   } tbbf_pix_type;

   // One result
   typedef struct packed {
      logic [INDEX_W-1:0] tile_index;
      logic               found;
      logic [POS_W-1:0]   box_x;
      logic [POS_W-1:0]   box_y;
      logic [DIM_W-1:0]   box_w;
      logic [DIM_W-1:0]   box_h;
      logic               last_tile;
   } tbbf_box_type;

endpackage

@@ hw/rtl/tbbf_ram.sv @@
module tbbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Registered read; a read of the entry being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/tbbf_scan.sv @@
module tbbf_scan
   import tbbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  tbbf_cfg_type        cfg,
   input  logic                accept,
   input  logic [ALPHA_W-1:0]  alpha,
   input  logic                frame_start,
   output logic [SLOT_W-1:0]   rd_addr,
   output logic                s1_valid,
   output tbbf_pix_type        s1_pix
);

   logic [DIM_W-1:0]  pixel_col_ff, pixel_col_in;
   logic [POS_W-1:0]  pixel_row_ff, pixel_row_in;
   logic [DIM_W-1:0]  col_in_tile_ff, col_in_tile_in;
   logic [DIM_W-1:0]  row_in_tile_ff, row_in_tile_in;
   logic [TCOL_W-1:0] tile_col_ff, tile_col_in;
   logic [DIM_W-1:0]  tile_row_ff, tile_row_in;
   logic              s1_valid_ff;
   tbbf_pix_type      pix_ff, pix_in;

   // position after a possible frame start
   logic [DIM_W-1:0]  pcol, cit, rit, trow;
   logic [POS_W-1:0]  prow;
   logic [TCOL_W-1:0] tcol;
   logic              frozen, tile_right, tile_bottom, row_end, in_cols;
   logic [19:0]       band_base;

   always_comb begin
      pcol = frame_start ? '0 : pixel_col_ff;
      prow = frame_start ? '0 : pixel_row_ff;
      cit  = frame_start ? '0 : col_in_tile_ff;
      rit  = frame_start ? '0 : row_in_tile_ff;
      tcol = frame_start ? '0 : tile_col_ff;
      trow = frame_start ? '0 : tile_row_ff;

      frozen      = trow >= cfg.td;
      tile_right  = (14'(cit) + 14'd1) >= 14'(cfg.tw);
      tile_bottom = (14'(rit) + 14'd1) >= 14'(cfg.th);
      row_end     = (14'(pcol) + 14'd1) >= 14'(cfg.iw);
      in_cols     = tcol < cfg.ta;
      band_base   = 20'(trow) * 20'(cfg.ta) + 20'(tcol);

      // beat for the update stage
      pix_in.active       = !frozen && in_cols;
      pix_in.emit         = !frozen && in_cols && tile_right && tile_bottom;
      pix_in.painted      = alpha != '0;
      pix_in.tile_right   = tile_right;
      pix_in.clear_before = frame_start;
      pix_in.clear_after  = !frozen && row_end && tile_bottom;
      pix_in.addr         = tcol[SLOT_W-1:0];
      pix_in.pixel_col    = pcol;
      pix_in.pixel_row    = prow;
      pix_in.row_in_tile  = rit;
      pix_in.tile_index   = band_base[INDEX_W-1:0];
      pix_in.last_tile    = ((14'(trow) + 14'd1) >= 14'(cfg.td))
                            && ((8'(tcol) + 8'd1) >= 8'(cfg.ta));

      // position advance; frozen past the grid
      pixel_col_in   = pcol;
      pixel_row_in   = prow;
      col_in_tile_in = cit;
      row_in_tile_in = rit;
      tile_col_in    = tcol;
      tile_row_in    = trow;
      if (!frozen) begin
         if (row_end) begin
            pixel_col_in   = '0;
            col_in_tile_in = '0;
            tile_col_in    = '0;
            pixel_row_in   = prow + 1'b1;
            if (tile_bottom) begin
               row_in_tile_in = '0;
               tile_row_in    = trow + 1'b1;
            end else begin
               row_in_tile_in = rit + 1'b1;
            end
         end else begin
            pixel_col_in = pcol + 1'b1;
            if (in_cols) begin
               if (tile_right) begin
                  col_in_tile_in = '0;
                  tile_col_in    = tcol + 1'b1;
               end else begin
                  col_in_tile_in = cit + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_col_ff   <= '0;
         pixel_row_ff   <= '0;
         col_in_tile_ff <= '0;
         row_in_tile_ff <= '0;
         tile_col_ff    <= '0;
         tile_row_ff    <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            pixel_col_ff   <= pixel_col_in;
            pixel_row_ff   <= pixel_row_in;
            col_in_tile_ff <= col_in_tile_in;
            row_in_tile_ff <= row_in_tile_in;
            tile_col_ff    <= tile_col_in;
            tile_row_ff    <= tile_row_in;
         end
      end
   end

   // payload of the stage register
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= pix_in;
      end
   end

   assign rd_addr  = pix_in.addr;
   assign s1_valid = s1_valid_ff;
   assign s1_pix   = pix_ff;

endmodule

@@ hw/rtl/tbbf_update.sv @@
module tbbf_update
   import tbbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                s1_valid,
   input  tbbf_pix_type        pix,
   input  tbbf_entry_type      rd_data,
   output logic                wr_en,
   output logic [SLOT_W-1:0]   wr_addr,
   output tbbf_entry_type      wr_data,
   output logic                push,
   output tbbf_box_type        box
);

   logic [TILE_SLOTS-1:0] valid_ff, valid_in;
   logic                  fwd_vld_ff;
   logic [SLOT_W-1:0]     fwd_addr_ff;
   tbbf_entry_type        fwd_data_ff;

   tbbf_entry_type        cur, nxt;
   tbbf_phase_type        phase;
   logic                  fwd_hit, vld, found;

   always_comb begin
      // last cycle's write is not yet in the read data
      fwd_hit = fwd_vld_ff && (fwd_addr_ff == pix.addr);
      cur     = fwd_hit ? fwd_data_ff : rd_data;
      vld     = valid_ff[pix.addr] && !pix.clear_before;
      phase   = vld ? cur.phase : PH_SEARCH;

      // read-modify-write of the tile column entry
      nxt       = cur;
      nxt.phase = phase;
      unique case (phase)
         PH_SEARCH: begin
            if (pix.painted) begin
               nxt.corner_col = pix.pixel_col;
               nxt.corner_row = pix.pixel_row;
               nxt.corner_rit = pix.row_in_tile;
               nxt.run_w      = DIM_W'(1);
               nxt.run_h      = DIM_W'(1);
               nxt.phase      = pix.tile_right ? PH_HEIGHT : PH_WIDTH;
            end
         end
         PH_WIDTH: begin
            if (pix.painted) begin
               nxt.run_w = cur.run_w + 1'b1;
               if (pix.tile_right) begin
                  nxt.phase = PH_HEIGHT;
               end
            end else begin
               nxt.phase = PH_HEIGHT;
            end
         end
         PH_HEIGHT: begin
            if (pix.pixel_col == cur.corner_col && pix.row_in_tile > cur.corner_rit) begin
               if (pix.painted) begin
                  nxt.run_h = cur.run_h + 1'b1;
               end else begin
                  nxt.phase = PH_DONE;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      wr_en   = s1_valid && pix.active;
      wr_addr = pix.addr;
      wr_data = nxt;

      // band clears around this beat's own entry update
      valid_in = valid_ff;
      if (s1_valid) begin
         if (pix.clear_before) begin
            valid_in = '0;
         end
         if (pix.active) begin
            valid_in[pix.addr] = 1'b1;
         end
         if (pix.clear_after) begin
            valid_in = '0;
         end
      end

      // result at the tile's bottom-right pixel
      found          = nxt.phase != PH_SEARCH;
      push           = s1_valid && pix.emit;
      box.tile_index = pix.tile_index;
      box.found      = found;
      box.box_x      = found ? nxt.corner_col[POS_W-1:0] : '0;
      box.box_y      = found ? nxt.corner_row : '0;
      box.box_w      = found ? nxt.run_w : '0;
      box.box_h      = found ? nxt.run_h : '0;
      box.last_tile  = pix.last_tile;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         fwd_vld_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

   // a band clear leaves every tile column searching
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      s1_valid && pix.clear_after |=> valid_ff == '0)
      else $error("tile columns still marked after band end");

   // an entry written inside a band is marked valid afterwards
   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      wr_en && !pix.clear_after |=> valid_ff[$past(wr_addr)])
      else $error("written entry not marked valid");

   // a not-found result carries an empty box
   a_empty_box: assert property (@(posedge clock) disable iff (reset)
      push && !box.found |-> box.box_w == '0 && box.box_h == '0 && box.box_x == '0)
      else $error("box fields set on an empty tile");

endmodule

@@ hw/rtl/tbbf_out_fifo.sv @@
module tbbf_out_fifo
   import tbbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tbbf_box_type          push_box,
   input  logic                  pop,
   output logic                  head_valid,
   output tbbf_box_type          head_box,
   output logic [FIFO_CNT_W-1:0] count
);

   tbbf_box_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_box;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_box   = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   // the input side stalls before the queue can overflow
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == FIFO_CNT_W'(FIFO_DEPTH) |-> !push || do_pop)
      else $error("result queue overflow");

endmodule

@@ hw/rtl/tile_bounding_box_finder_core.sv @@
// Tile bounding box finder. Takes one alpha pixel per beat in raster order and, at the
// bottom-right pixel of each tile of the grid, gives that tile's box: corner at the first
// painted pixel of the tile, width the painted run to the right, height the painted run
// down the corner's column, both clipped at the tile edge (found is 0 and the box zero when
// the tile held no painted pixel). A pixel beat is taken every cycle; the input stalls only
// while the four-deep result queue is full or about to be. With the queue empty, a result
// is offered once its pixel has passed the scan stage register and the result queue. The
// per tile column state lives in a 64-entry memory with a registered read, updated
// read-modify-write with forwarding of the previous cycle's write; flip-flop valid bits
// restart all tile columns at each new band and frame, so no clearing pass is needed after
// reset. Write the registers only while no pixel is in flight.
module tile_bounding_box_finder_core
   import tbbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] alpha
   input  logic                  req_tuser,   // [0] frame_start
   // box results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // [17:0] tile_index, [29:18] box_x,
                                              // [41:30] box_y, [54:42] box_w,
                                              // [67:55] box_h, rest zero
   output logic                  rsp_tuser,   // [0] found
   output logic                  rsp_tlast,   // last tile of the grid
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata
);

   logic [DIM_W-1:0]    image_width_ff, tile_width_ff, tile_height_ff, tiles_down_ff;
   logic [ACROSS_W-1:0] tiles_across_ff;
   tbbf_cfg_type        cfg;

   logic                  accept;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  s1_valid;
   tbbf_pix_type          s1_pix;
   tbbf_entry_type        rd_data, wr_data;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   logic                  push;
   tbbf_box_type          push_box, head_box;
   logic [FIFO_CNT_W-1:0] count;
   logic                  pending;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_W'(1024);
         tile_width_ff   <= DIM_W'(32);
         tile_height_ff  <= DIM_W'(32);
         tiles_across_ff <= ACROSS_W'(32);
         tiles_down_ff   <= DIM_W'(32);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_TILE_WIDTH:   tile_width_ff   <= csr_wdata;
            CSR_TILE_HEIGHT:  tile_height_ff  <= csr_wdata;
            CSR_TILES_ACROSS: tiles_across_ff <= csr_wdata[ACROSS_W-1:0];
            CSR_TILES_DOWN:   tiles_down_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // zero acts as one; tile columns clamp to the entry count
   always_comb begin
      cfg.iw = (image_width_ff == '0) ? DIM_W'(1) : image_width_ff;
      cfg.tw = (tile_width_ff == '0) ? DIM_W'(1) : tile_width_ff;
      cfg.th = (tile_height_ff == '0) ? DIM_W'(1) : tile_height_ff;
      cfg.td = (tiles_down_ff == '0) ? DIM_W'(1) : tiles_down_ff;
      priority if (tiles_across_ff == '0) begin
         cfg.ta = ACROSS_W'(1);
      end else if (tiles_across_ff > ACROSS_W'(TILE_SLOTS)) begin
         cfg.ta = ACROSS_W'(TILE_SLOTS);
      end else begin
         cfg.ta = tiles_across_ff;
      end
   end

   // room for the beat in flight and the one taken now
   assign pending    = s1_valid && s1_pix.emit;
   assign req_tready = (FIFO_CNT_W'(count) + FIFO_CNT_W'(pending))
                       < FIFO_CNT_W'(FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;

   tbbf_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accept      (accept),
      .alpha       (req_tdata),
      .frame_start (req_tuser),
      .rd_addr     (rd_addr),
      .s1_valid    (s1_valid),
      .s1_pix      (s1_pix)
   );

   tbbf_ram #(
      .WIDTH ($bits(tbbf_entry_type)),
      .DEPTH (TILE_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tbbf_update u_update (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .pix      (s1_pix),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .push     (push),
      .box      (push_box)
   );

   tbbf_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_box   (push_box),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_box   (head_box),
      .count      (count)
   );

   // result beat packing
   assign rsp_tdata = {4'b0, head_box.box_h, head_box.box_w, head_box.box_y,
                       head_box.box_x, head_box.tile_index};
   assign rsp_tuser = head_box.found;
   assign rsp_tlast = head_box.last_tile;

endmodule
